FILE: hw/rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and constants of the blind position controller.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_BLINDS = 4;

    localparam int CH_W   = 2;
    localparam int PCT_W  = 7;
    localparam int MS_W   = 32;
    localparam int TIME_W = 16;
    localparam int DIVS_W = 16;
    localparam int PROD_W = PCT_W + TIME_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0]       LVL_TOGGLE  = 8'hFF;
    localparam logic [7:0]       LVL_STOP    = 8'hC9;
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [MS_W-1:0]  OFF_HOLD_MS = 32'd20000;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SVC   = 2'd1,
        MODE_SET   = 2'd2,
        MODE_QUERY = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MS_DOWN  = 3'd0,
        REG_MS_UP    = 3'd1,
        REG_MS_TILT  = 3'd2,
        REG_SETTLE   = 3'd3,
        REG_END_XTRA = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        PH_STOP  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_TURN  = 3'd2,
        PH_MOVE  = 3'd3,
        PH_OFF   = 3'd4,
        PH_SWDIR = 3'd5
    } phase_t;

    typedef logic [PCT_W-1:0] pct_t;

    typedef struct packed {
        phase_t          cur;
        phase_t          nxt;
        logic            force_on;
        logic            down;
        pct_t            target;
        pct_t            saved;
        pct_t            actual;
        pct_t            start;
        pct_t            tilt;
        logic            known;
        logic            seeking;
        logic [MS_W-1:0] phase_start;
        logic [MS_W-1:0] due;
        logic            dir_pin;
        logic            act_pin;
    } chan_t;

    localparam chan_t CHAN_RESET = '{
        cur: PH_OFF, nxt: PH_OFF, force_on: 1'b0, down: 1'b0,
        target: '0, saved: '0, actual: '0, start: '0, tilt: '0,
        known: 1'b0, seeking: 1'b0, phase_start: '0, due: '0,
        dir_pin: 1'b1, act_pin: 1'b1
    };

endpackage

FILE: hw/rtl/bpc_div.sv
// ----------------------------------------------------------------------------
// bpc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bpc_div
    import bpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [MS_W-1:0]   dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic              done,
    output logic [MS_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(MS_W + 1);

    logic [DIVS_W:0]   rem_reg, rem_next;
    logic [MS_W-1:0]   quo_reg, quo_next;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIVS_W:0]   rem_sh;

    always_comb
    begin
        rem_sh    = {rem_reg[DIVS_W-1:0], quo_reg[MS_W-1]};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(MS_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[MS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[MS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: hw/rtl/blind_position_controller_core.sv
// ----------------------------------------------------------------------------
// blind_position_controller_core
// Time-based roller blind control for several channels with position estimate.
// ----------------------------------------------------------------------------
// Sequencing: an accepted item passes S_MUL, which registers the run time product,
// then S_EXEC, which writes the output register; with the position estimate it first
// waits in S_DIV for the shared serial divider. The next item is taken once the result
// is placed in the output register; a stalled output holds the sequencer in S_EXEC.
// Reset: all channels relay off, both relays off, position unknown, clock zero.
module blind_position_controller_core
    import bpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           mode,
    input  logic [CH_W-1:0]      channel,
    input  logic [7:0]           level,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CH_W-1:0]      out_channel,
    output logic                 dir_relay_high,
    output logic                 act_relay_high,
    output logic                 report_valid,
    output logic                 query_valid,
    output logic [PCT_W-1:0]     position,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIME_W-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_EXEC = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [TIME_W-1:0] ms_down_reg, ms_up_reg, settle_reg, extra_reg;
    logic [7:0]        ms_tilt_reg;
    logic [MS_W-1:0]   ms_clock_reg;
    chan_t             ch_reg [NUM_BLINDS];

    mode_t             mode_reg;
    logic [CH_W-1:0]   chan_reg;
    logic [7:0]        level_reg;
    logic              est_reg;
    logic [PROD_W-1:0] prod_reg, prod_next;

    logic              out_valid_reg;
    logic [CH_W-1:0]   out_channel_reg;
    logic              out_dir_reg, out_act_reg, out_rep_reg, out_qry_reg;
    pct_t              out_pos_reg;

    logic              in_accept, in_range_in, in_range_reg, slot_free;
    chan_t             ch_in, s0, se, s_new;
    logic              need_est;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_done;
    logic [MS_W-1:0]   div_quo;
    logic              reported, queried;
    pct_t              rep_pct;
    pct_t              d_move, d_tilt;
    logic [PCT_W-1:0]  mul_a;
    logic [TIME_W-1:0] mul_b;

    function automatic logic [TIME_W-1:0] nz(logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

    function automatic chan_t est_apply(chan_t s, logic [MS_W-1:0] q);
        chan_t r;
        r = s;
        if (s.cur == PH_MOVE)
        begin
            if (s.down)
            begin
                r.actual = (q >= MS_W'(PCT_MAX - s.start)) ? PCT_MAX : s.start + q[PCT_W-1:0];
                r.tilt   = PCT_MAX;
            end
            else
            begin
                r.actual = (q >= MS_W'(s.start)) ? '0 : s.start - q[PCT_W-1:0];
                r.tilt   = '0;
            end
        end
        else if (s.cur == PH_TURN)
        begin
            if (s.down)
            begin
                r.tilt = (q >= MS_W'(PCT_MAX - s.tilt)) ? PCT_MAX : s.tilt + q[PCT_W-1:0];
            end
            else
            begin
                r.tilt = (q >= MS_W'(s.tilt)) ? '0 : s.tilt - q[PCT_W-1:0];
            end
        end
        return r;
    endfunction

    // Position estimate is already applied to s where the command needs it.
    function automatic chan_t set_level(chan_t s, logic [7:0] lvl);
        chan_t r;
        pct_t  t;
        r = s;
        t = (lvl[7:1] > PCT_MAX) ? PCT_MAX : lvl[7:1];
        if (lvl == LVL_TOGGLE)
        begin
            if (r.cur == PH_TURN)
            begin
                r.nxt = PH_STOP;
            end
            r.force_on = 1'b1;
            if (r.cur == PH_STOP || r.cur == PH_OFF)
            begin
                r.target = r.down ? '0 : PCT_MAX;
                r.nxt    = PH_WAIT;
                if (!r.known)
                begin
                    r.actual = r.down ? PCT_MAX : '0;
                end
            end
        end
        else if (lvl == LVL_STOP)
        begin
            r.nxt      = PH_STOP;
            r.force_on = 1'b1;
        end
        else
        begin
            r.target = t;
            if (r.cur == PH_TURN || r.cur == PH_MOVE)
            begin
                if ((!r.down && t > r.actual) || (r.down && t < r.actual))
                begin
                    r.nxt      = PH_SWDIR;
                    r.force_on = 1'b1;
                end
                else if (r.cur == PH_MOVE)
                begin
                    r.nxt      = PH_MOVE;
                    r.force_on = 1'b1;
                end
            end
            else if (t != r.actual)
            begin
                r.nxt      = PH_WAIT;
                r.force_on = 1'b1;
            end
            if (!r.known)
            begin
                if (t == '0)
                begin
                    r.actual = PCT_MAX;
                end
                else if (t == PCT_MAX)
                begin
                    r.actual = '0;
                end
                else
                begin
                    r.actual  = PCT_MAX;
                    r.saved   = t;
                    r.target  = '0;
                    r.seeking = 1'b1;
                end
            end
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // ---- item intake --------------------------------------------------------
    assign in_range_in = ({1'b0, channel} < (CH_W + 1)'(NUM_BLINDS));
    assign ch_in       = ch_reg[channel];

    always_comb
    begin
        need_est = 1'b0;
        if (in_range_in && (ch_in.cur == PH_MOVE || ch_in.cur == PH_TURN))
        begin
            unique case (mode_t'(mode))
                MODE_QUERY: need_est = 1'b1;
                MODE_SET:   need_est = (level != LVL_TOGGLE) && (level != LVL_STOP);
                MODE_SVC:   need_est = ch_in.force_on && (ch_in.nxt == PH_STOP);
                MODE_TICK:  need_est = 1'b0;
                default:    need_est = 1'b0;
            endcase
        end
        if (ch_in.cur == PH_TURN)
        begin
            div_divisor = {8'b0, (ms_tilt_reg == 8'd0) ? 8'd1 : ms_tilt_reg};
        end
        else
        begin
            div_divisor = ch_in.down ? nz(ms_down_reg) : nz(ms_up_reg);
        end
    end

    bpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept && need_est),
        .dividend (ms_clock_reg - ch_in.phase_start),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ---- run time product for turn and move ---------------------------------
    assign s0 = ch_reg[chan_reg];

    always_comb
    begin
        d_tilt = s0.down ? ((s0.tilt >= PCT_MAX) ? '0 : PCT_MAX - s0.tilt) : s0.tilt;
        if (s0.down)
        begin
            d_move = (s0.target > s0.actual) ? s0.target - s0.actual : '0;
        end
        else
        begin
            d_move = (s0.actual > s0.target) ? s0.actual - s0.target : '0;
        end
        if (s0.nxt == PH_TURN)
        begin
            mul_a = d_tilt;
            mul_b = {8'b0, ms_tilt_reg};
        end
        else
        begin
            mul_a = d_move;
            mul_b = s0.down ? ms_down_reg : ms_up_reg;
        end
        prod_next = mul_a * mul_b;
    end

    // ---- execute the command on one channel ---------------------------------
    always_comb
    begin
        se       = est_reg ? est_apply(s0, div_quo) : s0;
        s_new    = se;
        reported = 1'b0;
        queried  = 1'b0;
        rep_pct  = '0;
        unique case (mode_reg)
            MODE_TICK:
            begin
            end
            MODE_SET:
            begin
                s_new = set_level(se, level_reg);
            end
            MODE_QUERY:
            begin
                queried = 1'b1;
            end
            MODE_SVC:
            begin
                if (se.force_on || ms_clock_reg >= se.due)
                begin
                    unique case (se.nxt)
                        PH_OFF:
                        begin
                            s_new.dir_pin = 1'b1;
                            s_new.cur     = PH_OFF;
                            s_new.due     = ms_clock_reg + OFF_HOLD_MS;
                        end
                        PH_WAIT:
                        begin
                            s_new.down     = (se.target > se.actual);
                            s_new.dir_pin  = (se.target > se.actual);
                            s_new.cur      = PH_WAIT;
                            s_new.nxt      = PH_TURN;
                            s_new.force_on = 1'b0;
                            s_new.due      = ms_clock_reg + MS_W'(settle_reg);
                        end
                        PH_TURN:
                        begin
                            s_new.act_pin     = 1'b0;
                            s_new.phase_start = ms_clock_reg;
                            s_new.cur         = PH_TURN;
                            s_new.nxt         = PH_MOVE;
                            s_new.due         = ms_clock_reg + MS_W'(prod_reg);
                        end
                        PH_MOVE:
                        begin
                            s_new.act_pin     = 1'b0;
                            s_new.phase_start = ms_clock_reg;
                            s_new.start       = se.actual;
                            s_new.cur         = PH_MOVE;
                            s_new.nxt         = PH_STOP;
                            s_new.due         = ms_clock_reg + MS_W'(prod_reg)
                                + ((se.target == '0 || se.target == PCT_MAX)
                                   ? MS_W'(extra_reg) : '0);
                            s_new.force_on    = 1'b0;
                        end
                        PH_STOP:
                        begin
                            if (se.force_on)
                            begin
                                s_new.force_on = 1'b0;
                                s_new.target   = se.actual;
                            end
                            else
                            begin
                                s_new.actual = se.target;
                                s_new.tilt   = se.down ? PCT_MAX : '0;
                                if (!se.known && (se.target == '0 || se.target == PCT_MAX))
                                begin
                                    s_new.known = 1'b1;
                                end
                            end
                            rep_pct       = s_new.actual;
                            reported      = 1'b1;
                            s_new.act_pin = 1'b1;
                            s_new.cur     = PH_STOP;
                            s_new.nxt     = PH_OFF;
                            s_new.due     = ms_clock_reg + MS_W'(settle_reg);
                            if (se.seeking)
                            begin
                                s_new = set_level(s_new, {s_new.saved, 1'b0});
                                s_new.seeking = 1'b0;
                            end
                        end
                        PH_SWDIR:
                        begin
                            s_new.act_pin  = 1'b1;
                            s_new.cur      = PH_SWDIR;
                            s_new.nxt      = PH_WAIT;
                            s_new.force_on = 1'b0;
                            s_new.due      = ms_clock_reg + MS_W'(settle_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---- sequencer ----------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = need_est ? S_DIV : S_MUL;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ms_clock_reg  <= '0;
            out_valid_reg <= 1'b0;
            ms_down_reg   <= TIME_W'(200);
            ms_up_reg     <= TIME_W'(200);
            ms_tilt_reg   <= 8'd20;
            settle_reg    <= TIME_W'(200);
            extra_reg     <= TIME_W'(1000);
            for (int i = 0; i < NUM_BLINDS; i++)
            begin
                ch_reg[i] <= CHAN_RESET;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MS_DOWN:  ms_down_reg <= cfg_data;
                    REG_MS_UP:    ms_up_reg   <= cfg_data;
                    REG_MS_TILT:  ms_tilt_reg <= cfg_data[7:0];
                    REG_SETTLE:   settle_reg  <= cfg_data;
                    REG_END_XTRA: extra_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_EXEC && slot_free)
            begin
                out_valid_reg <= 1'b1;
                if (mode_reg == MODE_TICK)
                begin
                    ms_clock_reg <= ms_clock_reg + MS_W'(1);
                end
                else if (in_range_reg)
                begin
                    ch_reg[chan_reg] <= s_new;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mode_reg     <= mode_t'(mode);
            chan_reg     <= channel;
            level_reg    <= level;
            est_reg      <= need_est;
            in_range_reg <= in_range_in;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (state_reg == S_EXEC && slot_free)
        begin
            out_channel_reg <= chan_reg;
            if (in_range_reg)
            begin
                out_dir_reg <= s_new.dir_pin;
                out_act_reg <= s_new.act_pin;
                out_rep_reg <= reported;
                out_qry_reg <= queried;
                out_pos_reg <= reported ? rep_pct : s_new.actual;
            end
            else
            begin
                out_dir_reg <= 1'b1;
                out_act_reg <= 1'b1;
                out_rep_reg <= 1'b0;
                out_qry_reg <= 1'b0;
                out_pos_reg <= '0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_channel    = out_channel_reg;
    assign dir_relay_high = out_dir_reg;
    assign act_relay_high = out_act_reg;
    assign report_valid   = out_rep_reg;
    assign query_valid    = out_qry_reg;
    assign position       = out_pos_reg;

endmodule

FILE: hw/rtl/bpc_checker.sv
// ----------------------------------------------------------------------------
// bpc_checker
// Port-level checks of the blind position controller, bound to the top level.
// ----------------------------------------------------------------------------
module bpc_checker
    import bpc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic             report_valid,
    input logic             query_valid,
    input logic             act_relay_high,
    input logic [PCT_W-1:0] position
);

    // one item at a time: an accepted item blocks intake on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("intake not blocked after item accept");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(report_valid && query_valid))
        else $error("report and query flagged together");

    a_stop_relay_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_valid |-> act_relay_high)
        else $error("stop report with active relay on");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position))
        else $error("stalled result changed");

endmodule

bind blind_position_controller_core bpc_checker u_bpc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .report_valid   (report_valid),
    .query_valid    (query_valid),
    .act_relay_high (act_relay_high),
    .position       (position)
);

FILE: tb/tb_blind_position_controller_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_blind_position_controller_core
// Self-checking bench: a table of directed items, then random well-formed
// command and tick traffic over several timing settings and handshake
// pressure, each result checked against a behavioral blind controller or, for typed rows, the table.
// ----------------------------------------------------------------------------
module tb_blind_position_controller_core;
    import bpc_pkg::*;

    typedef struct {
        logic [1:0] ch;
        logic       dir;
        logic       act;
        logic       rep;
        logic       qry;
        logic [6:0] pos;
    } blind_result_t;

    typedef struct {
        mode_t      m;
        int         ch;
        int         lvl;
        bit         typed;
        logic       dir;
        logic       act;
        logic       qry;
        logic [6:0] pos;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           mode = '0;
    logic [CH_W-1:0]      channel = '0;
    logic [7:0]           level = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CH_W-1:0]      out_channel;
    logic                 dir_relay_high;
    logic                 act_relay_high;
    logic                 report_valid;
    logic                 query_valid;
    logic [PCT_W-1:0]     position;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;

    blind_position_controller_core dut (.*);

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Behavioral blind controller
    // ------------------------------------------------------------------
    int unsigned ms_down, ms_up, ms_tilt, settle_ms, extra_ms;
    logic [31:0] ms_now;
    phase_t      ph_cur [NUM_BLINDS];
    phase_t      ph_next[NUM_BLINDS];
    bit          forced[NUM_BLINDS], going_down[NUM_BLINDS];
    bit          known[NUM_BLINDS], seeking[NUM_BLINDS];
    bit          dir_q[NUM_BLINDS], act_q[NUM_BLINDS];
    int unsigned target[NUM_BLINDS], saved[NUM_BLINDS], actual[NUM_BLINDS];
    int unsigned start_at[NUM_BLINDS], tilt[NUM_BLINDS];
    logic [31:0] t_start[NUM_BLINDS], t_due[NUM_BLINDS];

    blind_result_t pending_results[$];
    int errors = 0, n_items = 0, n_reports = 0, n_queries = 0;
    int sender_mode = 0, receiver_mode = 0;
    bit hold_req = 0;
    int hold_left = 0;

    function automatic int unsigned nz(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function void blinds_reset();
        ms_down = 200; ms_up = 200; ms_tilt = 20; settle_ms = 200; extra_ms = 1000;
        ms_now = '0;
        for (int c = 0; c < NUM_BLINDS; c++)
        begin
            ph_cur[c] = PH_OFF; ph_next[c] = PH_OFF;
            forced[c] = 0; going_down[c] = 0; known[c] = 0; seeking[c] = 0;
            target[c] = 0; saved[c] = 0; actual[c] = 0; start_at[c] = 0; tilt[c] = 0;
            t_start[c] = '0; t_due[c] = '0; dir_q[c] = 1; act_q[c] = 1;
        end
    endfunction

    function void update_estimate(int c);
        logic [31:0] el;
        int unsigned q;
        el = ms_now - t_start[c];
        if (ph_cur[c] == PH_MOVE)
        begin
            if (going_down[c])
            begin
                q = el / nz(ms_down);
                actual[c] = (q >= 100 - start_at[c]) ? 100 : start_at[c] + q;
                tilt[c] = 100;
            end
            else
            begin
                q = el / nz(ms_up);
                actual[c] = (q >= start_at[c]) ? 0 : start_at[c] - q;
                tilt[c] = 0;
            end
        end
        else if (ph_cur[c] == PH_TURN)
        begin
            q = el / nz(ms_tilt);
            if (going_down[c])
                tilt[c] = (q >= 100 - tilt[c]) ? 100 : tilt[c] + q;
            else
                tilt[c] = (q >= tilt[c]) ? 0 : tilt[c] - q;
        end
    endfunction

    function void apply_level(int c, int unsigned lvl);
        int unsigned t;
        if (lvl == LVL_TOGGLE)
        begin
            if (ph_cur[c] == PH_TURN)
                ph_next[c] = PH_STOP;
            forced[c] = 1;
            if (ph_cur[c] == PH_STOP || ph_cur[c] == PH_OFF)
            begin
                target[c] = going_down[c] ? 0 : 100;
                ph_next[c] = PH_WAIT;
                if (!known[c])
                    actual[c] = going_down[c] ? 100 : 0;
            end
        end
        else if (lvl == LVL_STOP)
        begin
            ph_next[c] = PH_STOP;
            forced[c] = 1;
        end
        else
        begin
            t = lvl >> 1;
            target[c] = (t > 100) ? 100 : t;
            if (ph_cur[c] == PH_TURN || ph_cur[c] == PH_MOVE)
            begin
                update_estimate(c);
                if ((!going_down[c] && target[c] > actual[c]) ||
                    (going_down[c] && target[c] < actual[c]))
                begin
                    ph_next[c] = PH_SWDIR;
                    forced[c] = 1;
                end
                else if (ph_cur[c] == PH_MOVE)
                begin
                    ph_next[c] = PH_MOVE;
                    forced[c] = 1;
                end
            end
            else if (target[c] != actual[c])
            begin
                ph_next[c] = PH_WAIT;
                forced[c] = 1;
            end
            if (!known[c])
            begin
                if (target[c] == 0)
                    actual[c] = 100;
                else if (target[c] == 100)
                    actual[c] = 0;
                else
                begin
                    actual[c] = 100;
                    saved[c] = target[c];
                    target[c] = 0;
                    seeking[c] = 1;
                end
            end
        end
    endfunction

    // Returns 1 when a stop ran and reports its position.
    function bit run_phase(int c, output int unsigned rep);
        int unsigned d;
        rep = 0;
        if (!(forced[c] || ms_now >= t_due[c]))
            return 0;
        case (ph_next[c])
            PH_OFF:
            begin
                dir_q[c] = 1;
                ph_cur[c] = PH_OFF;
                t_due[c] = ms_now + OFF_HOLD_MS;
            end
            PH_WAIT:
            begin
                going_down[c] = target[c] > actual[c];
                dir_q[c] = going_down[c];
                ph_cur[c] = PH_WAIT;
                ph_next[c] = PH_TURN;
                forced[c] = 0;
                t_due[c] = ms_now + settle_ms;
            end
            PH_TURN:
            begin
                act_q[c] = 0;
                t_start[c] = ms_now;
                ph_cur[c] = PH_TURN;
                ph_next[c] = PH_MOVE;
                d = going_down[c] ? ((tilt[c] >= 100) ? 0 : 100 - tilt[c]) : tilt[c];
                t_due[c] = ms_now + d * ms_tilt;
            end
            PH_MOVE:
            begin
                act_q[c] = 0;
                t_start[c] = ms_now;
                start_at[c] = actual[c];
                ph_cur[c] = PH_MOVE;
                ph_next[c] = PH_STOP;
                if (going_down[c])
                begin
                    d = (target[c] > actual[c]) ? target[c] - actual[c] : 0;
                    t_due[c] = ms_now + d * ms_down;
                end
                else
                begin
                    d = (actual[c] > target[c]) ? actual[c] - target[c] : 0;
                    t_due[c] = ms_now + d * ms_up;
                end
                if (target[c] == 0 || target[c] == 100)
                    t_due[c] = t_due[c] + extra_ms;
                forced[c] = 0;
            end
            PH_STOP:
            begin
                if (forced[c])
                begin
                    forced[c] = 0;
                    update_estimate(c);
                    target[c] = actual[c];
                end
                else
                begin
                    actual[c] = target[c];
                    tilt[c] = going_down[c] ? 100 : 0;
                    if (!known[c] && (target[c] == 0 || target[c] == 100))
                        known[c] = 1;
                end
                rep = actual[c];
                act_q[c] = 1;
                ph_cur[c] = PH_STOP;
                ph_next[c] = PH_OFF;
                t_due[c] = ms_now + settle_ms;
                if (seeking[c])
                begin
                    apply_level(c, saved[c] * 2);
                    seeking[c] = 0;
                end
                return 1;
            end
            PH_SWDIR:
            begin
                act_q[c] = 1;
                ph_cur[c] = PH_SWDIR;
                ph_next[c] = PH_WAIT;
                forced[c] = 0;
                t_due[c] = ms_now + settle_ms;
            end
            default: ;
        endcase
        return 0;
    endfunction

    function blind_result_t blind_step(mode_t m, int c, int unsigned lvl);
        blind_result_t r;
        int unsigned rep;
        bit reported;
        reported = 0;
        rep = 0;
        if (m == MODE_TICK)
            ms_now = ms_now + 1;
        if (m == MODE_SVC)
            reported = run_phase(c, rep);
        else if (m == MODE_SET)
            apply_level(c, lvl);
        else if (m == MODE_QUERY)
            update_estimate(c);
        r.ch = 2'(c);
        r.dir = dir_q[c];
        r.act = act_q[c];
        r.rep = reported;
        r.qry = (m == MODE_QUERY);
        r.pos = reported ? 7'(rep) : 7'(actual[c]);
        return r;
    endfunction

    function void write_timing(cfg_reg_t idx, int unsigned v);
        case (idx)
            REG_MS_DOWN:  ms_down = v & 16'hFFFF;
            REG_MS_UP:    ms_up = v & 16'hFFFF;
            REG_MS_TILT:  ms_tilt = v & 8'hFF;
            REG_SETTLE:   settle_ms = v & 16'hFFFF;
            REG_END_XTRA: extra_ms = v & 16'hFFFF;
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    function automatic bit idle_roll(int how);
        case (how)
            1: return $urandom_range(99) < 84;
            2: return $urandom_range(99) < 13;
            default: return 0;
        endcase
    endfunction

    task automatic send_item(mode_t m, int c, int lvl, bit typed, blind_result_t typed_res);
        blind_result_t r;
        @(negedge clk);
        while (idle_roll(sender_mode == 1 ? 1 : (sender_mode == 3 ? 2 : 0)))
        begin
            in_valid = 1'b0;
            mode = 2'($urandom);
            channel = CH_W'($urandom);
            level = 8'($urandom);
            @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        channel = CH_W'(c);
        level = 8'(lvl);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = blind_step(m, c, lvl);
        pending_results.push_back(typed ? typed_res : r);
        n_items++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // let any estimate still running settle before touching registers
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int unsigned v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = TIME_W'(v);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        write_timing(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic random_items(int count);
        blind_result_t unused;
        int w, lvl;
        mode_t m;
        unused = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            w = $urandom_range(99);
            lvl = $urandom_range(255);
            if (w < 50)
                m = MODE_TICK;
            else if (w < 78)
                m = MODE_SVC;
            else if (w < 90)
            begin
                m = MODE_SET;
                w = $urandom_range(99);
                if (w < 25)
                    lvl = LVL_TOGGLE;
                else if (w < 40)
                    lvl = LVL_STOP;
                else if (w < 85)
                    lvl = 2 * $urandom_range(100);
            end
            else
                m = MODE_QUERY;
            send_item(m, $urandom_range(NUM_BLINDS - 1), lvl, 0, unused);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver and result checking
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_left = 400;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else if (receiver_mode == 1)
            out_stall = idle_roll(1);
        else if (receiver_mode == 2)
            out_stall = idle_roll(2);
        else
            out_stall = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        blind_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected item", 1, 0);
            else
            begin
                e = pending_results.pop_front();
                if (out_channel !== e.ch) report_mismatch("out_channel", out_channel, e.ch);
                if (dir_relay_high !== e.dir) report_mismatch("dir_relay_high", dir_relay_high, e.dir);
                if (act_relay_high !== e.act) report_mismatch("act_relay_high", act_relay_high, e.act);
                if (report_valid !== e.rep) report_mismatch("report_valid", report_valid, e.rep);
                if (query_valid !== e.qry) report_mismatch("query_valid", query_valid, e.qry);
                if (position !== e.pos) report_mismatch("position", position, e.pos);
                n_reports += report_valid;
                n_queries += query_valid;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    row_t directed[] = '{
        '{MODE_QUERY, 0, 0,   1, 1'b1, 1'b1, 1'b1, 7'd0},
        '{MODE_TICK,  3, 255, 1, 1'b1, 1'b1, 1'b0, 7'd0},
        '{MODE_SVC,   1, 0,   1, 1'b1, 1'b1, 1'b0, 7'd0},
        '{MODE_SET,   0, 255, 0, 0, 0, 0, 0},
        '{MODE_SVC,   0, 0,   0, 0, 0, 0, 0},
        '{MODE_SVC,   0, 0,   0, 0, 0, 0, 0},
        '{MODE_QUERY, 0, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   0, 201, 0, 0, 0, 0, 0},
        '{MODE_SVC,   0, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   1, 201, 0, 0, 0, 0, 0},
        '{MODE_SVC,   1, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   2, 254, 0, 0, 0, 0, 0},
        '{MODE_SVC,   2, 0,   0, 0, 0, 0, 0},
        '{MODE_SVC,   2, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   2, 0,   0, 0, 0, 0, 0},
        '{MODE_SVC,   2, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   3, 101, 0, 0, 0, 0, 0},
        '{MODE_SVC,   3, 0,   0, 0, 0, 0, 0},
        '{MODE_SET,   3, 200, 0, 0, 0, 0, 0},
        '{MODE_SET,   3, 1,   0, 0, 0, 0, 0},
        '{MODE_QUERY, 3, 0,   0, 0, 0, 0, 0},
        '{MODE_TICK,  0, 0,   0, 0, 0, 0, 0},
        '{MODE_SVC,   3, 0,   0, 0, 0, 0, 0}
    };

    int unsigned timing_sets[5][5] = '{
        '{1, 1, 1, 0, 0},
        '{3, 2, 4, 2, 6},
        '{65535, 65535, 255, 65535, 65535},
        '{0, 1, 0, 1, 1},
        '{2, 3, 1, 1, 65535}
    };
    int phase_items[5] = '{260, 240, 100, 240, 240};
    int phase_sender[5] = '{0, 1, 3, 0, 3};
    int phase_receiver[5] = '{0, 0, 2, 1, 2};

    initial
    begin
        blind_result_t tr;
        blinds_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
        begin
            tr = '{ch: 2'(directed[i].ch), dir: directed[i].dir, act: directed[i].act,
                   rep: 1'b0, qry: directed[i].qry, pos: directed[i].pos};
            send_item(directed[i].m, directed[i].ch, directed[i].lvl, directed[i].typed, tr);
        end
        drain();

        for (int p = 0; p < 5; p++)
        begin
            for (int r = 0; r < 5; r++)
                write_reg(cfg_reg_t'(r), timing_sets[p][r]);
            sender_mode = phase_sender[p];
            receiver_mode = phase_receiver[p];
            if (p == 1)
            begin
                // hold the output long enough that the input backs up
                random_items(20);
                hold_req = 1;
            end
            random_items(phase_items[p]);
            drain();
        end

        $display("covered %0d items over 6 timing settings: %0d stop reports, %0d queries",
                 n_items, n_reports, n_queries);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_div.sv
hw/rtl/blind_position_controller_core.sv
hw/rtl/bpc_checker.sv
tb/tb_blind_position_controller_core.sv
